/* sv/hpps_pkg.sv */
package hpps_pkg;

  localparam int WINDOW_W   = 63;
  localparam int TIME_W     = 63;
  localparam int FRAME_W    = 32;
  localparam int PTIME_W    = 32;
  localparam int VM_ID_W    = 16;
  localparam int LIMIT_W    = 31;
  localparam int COUNT_W    = 31;
  localparam int SEL_W      = 11;
  localparam int TIME_SHIFT = 20;
  localparam int VM_SLOTS   = 4;
  localparam int VM_IDX_W   = 2;
  localparam int CFG_IDX_W  = 3;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 63'd3000000000;

  localparam int NUM_VMS_DEF    = 4;
  localparam int MAX_SELECT_DEF = 1024;
  localparam int MAX_PAGES_DEF  = 2048;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VM0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VM1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VM2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VM3 = 3'd4;

  // classified page record, front to back
  typedef struct packed {
    logic                first;
    logic                cold;
    logic                in_fast;
    logic                vm_ok;
    logic [VM_IDX_W-1:0] vm_idx;
    logic [LIMIT_W-1:0]  limit;
    logic [COUNT_W-1:0]  fast_count;
    logic [FRAME_W-1:0]  frame;
  } item_t;

  typedef struct packed {
    logic               selected;
    logic [FRAME_W-1:0] frame;
    logic               to_fast;
    logic               migrate_needed;
    logic [SEL_W-1:0]   selected_count;
    logic               scan_stopped;
  } result_t;

endpackage

/* sv/hpps_fifo.sv */
module hpps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop) rd_ptr_r <= bump(rd_ptr_r);
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

/* sv/hpps_front.sv */
module hpps_front import hpps_pkg::*; #(
  parameter int NUM_VMS = NUM_VMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WINDOW_W-1:0]  cfg_wdata,
  input  logic                 first_of_scan,
  input  logic [TIME_W-1:0]    now_time,
  input  logic [FRAME_W-1:0]   page_frame,
  input  logic [PTIME_W-1:0]   page_time,
  input  logic                 owner_valid,
  input  logic [VM_ID_W-1:0]   owner_vm,
  input  logic                 in_fast_memory,
  input  logic [COUNT_W-1:0]   owner_fast_count,
  output item_t                item
);

  logic [WINDOW_W-1:0] window_r;
  logic [LIMIT_W-1:0]  limit_r [VM_SLOTS];
  logic [63:0]         age_edge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      for (int i = 0; i < VM_SLOTS; i++) limit_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW:    window_r   <= cfg_wdata;
        CFG_LIMIT_VM0: limit_r[0] <= cfg_wdata[LIMIT_W-1:0];
        CFG_LIMIT_VM1: limit_r[1] <= cfg_wdata[LIMIT_W-1:0];
        CFG_LIMIT_VM2: limit_r[2] <= cfg_wdata[LIMIT_W-1:0];
        CFG_LIMIT_VM3: limit_r[3] <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // 52-bit shifted time plus 63-bit window never exceeds 64 bits
  assign age_edge = {12'd0, page_time, 20'd0} + {1'b0, window_r};

  always_comb begin
    item            = '0;
    item.first      = first_of_scan;
    item.cold       = (age_edge < {1'b0, now_time});
    item.in_fast    = in_fast_memory;
    item.vm_ok      = owner_valid && (owner_vm < VM_ID_W'(NUM_VMS));
    item.vm_idx     = owner_vm[VM_IDX_W-1:0];
    item.limit      = limit_r[owner_vm[VM_IDX_W-1:0]];
    item.fast_count = owner_fast_count;
    item.frame      = page_frame;
  end

endmodule

/* sv/hpps_back.sv */
module hpps_back import hpps_pkg::*; #(
  parameter int NUM_VMS    = NUM_VMS_DEF,
  parameter int MAX_SELECT = MAX_SELECT_DEF,
  parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    go,
  input  item_t   item,
  output result_t result
);

  localparam int VMI_W  = (NUM_VMS > 1) ? $clog2(NUM_VMS) : 1;
  localparam int SCAN_W = $clog2(MAX_PAGES + 1);

  typedef enum logic [1:0] {CHK_OVER, CHK_ROOM, CHK_AT} chk_t;

  logic [COUNT_W-1:0] exp_r [NUM_VMS];
  logic [SEL_W-1:0]   sel_cnt_r, sel_cnt_nxt;
  logic [SCAN_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic               migrate_r, migrate_nxt;
  logic               stopped_r, stopped_nxt;

  logic [VMI_W-1:0]   vmi;
  logic               stop_cur, mig_cur;
  logic [SEL_W-1:0]   sel_cur;
  logic [SCAN_W-1:0]  scan_cur;
  logic [COUNT_W-1:0] ex_cur, ex_base, ex_nxt;
  logic               ex_wr;
  chk_t               chk;
  logic               sel, fast;

  assign vmi = item.vm_idx[VMI_W-1:0];

  always_comb begin
    // a first beat sees the scan state as cleared
    stop_cur = item.first ? 1'b0 : stopped_r;
    mig_cur  = item.first ? 1'b0 : migrate_r;
    sel_cur  = item.first ? '0 : sel_cnt_r;
    scan_cur = item.first ? '0 : scan_cnt_r;
    ex_cur   = item.first ? '0 : exp_r[vmi];
    ex_base  = (ex_cur == '0) ? item.fast_count : ex_cur;
    ex_nxt   = ex_base;
    ex_wr    = 1'b0;
    chk      = CHK_OVER;

    if (!item.vm_ok) begin
      chk = CHK_OVER;
    end else if (item.limit == '0) begin
      chk = CHK_ROOM;
    end else begin
      ex_wr = 1'b1;
      priority if (ex_base == item.limit) begin
        chk = CHK_AT;
      end else if (ex_base < item.limit) begin
        chk    = CHK_ROOM;
        ex_nxt = ex_base + 1'b1;
      end else begin
        chk    = CHK_OVER;
        ex_nxt = ex_base - 1'b1;
      end
    end

    sel         = 1'b0;
    fast        = 1'b0;
    migrate_nxt = mig_cur;
    if (!stop_cur) begin
      if (item.cold) begin
        sel = 1'b1;
        if (item.in_fast) migrate_nxt = 1'b1;
      end else if (!item.in_fast) begin
        if (chk == CHK_ROOM) begin
          sel         = 1'b1;
          fast        = 1'b1;
          migrate_nxt = 1'b1;
        end
      end else if (chk == CHK_OVER) begin
        sel         = 1'b1;
        migrate_nxt = 1'b1;
      end
    end

    if (stop_cur) begin
      sel_cnt_nxt  = sel_cur;
      scan_cnt_nxt = scan_cur;
      stopped_nxt  = 1'b1;
    end else begin
      sel_cnt_nxt  = sel_cur + SEL_W'(sel);
      scan_cnt_nxt = scan_cur + 1'b1;
      stopped_nxt  = (sel_cnt_nxt >= SEL_W'(MAX_SELECT)) ||
                     (scan_cnt_nxt >= SCAN_W'(MAX_PAGES));
    end

    result.selected       = sel;
    result.frame          = item.frame;
    result.to_fast        = fast;
    result.migrate_needed = migrate_nxt;
    result.selected_count = sel_cnt_nxt;
    result.scan_stopped   = stopped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VMS; i++) exp_r[i] <= '0;
      sel_cnt_r  <= '0;
      scan_cnt_r <= '0;
      migrate_r  <= 1'b0;
      stopped_r  <= 1'b0;
    end else if (go) begin
      for (int i = 0; i < NUM_VMS; i++) begin
        if (!stop_cur && ex_wr && (vmi == VMI_W'(i))) exp_r[i] <= ex_nxt;
        else if (item.first) exp_r[i] <= '0;
      end
      sel_cnt_r  <= sel_cnt_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      migrate_r  <= migrate_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

/* sv/hot_page_placement_selector_core.sv */
// A beat moves from the classify queue through the tracker stage into the result queue.
// Throughput: one page record per cycle while the queues have room; the per-VM tracker
//   update is a read-modify-write in the back stage, so beats may follow back to back.
// A two-entry queue splits the classify stage from the tracker stage, another one
//   holds results, so a stalled consumer does not block input until both fill.
// Reset (rst_n low, synchronous) empties both queues, clears trackers and counters,
//   and loads the window register with 3 s and all VM limits with zero.
module hot_page_placement_selector_core import hpps_pkg::*; #(
  parameter int NUM_VMS    = NUM_VMS_DEF,
  parameter int MAX_SELECT = MAX_SELECT_DEF,
  parameter int MAX_PAGES  = MAX_PAGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WINDOW_W-1:0]  cfg_wdata,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_first_of_scan,
  input  logic [TIME_W-1:0]    in_now_time,
  input  logic [FRAME_W-1:0]   in_page_frame,
  input  logic [PTIME_W-1:0]   in_page_time,
  input  logic                 in_owner_valid,
  input  logic [VM_ID_W-1:0]   in_owner_vm,
  input  logic                 in_fast_memory,
  input  logic [COUNT_W-1:0]   in_owner_fast_count,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_selected,
  output logic [FRAME_W-1:0]   out_frame,
  output logic                 out_to_fast,
  output logic                 out_migrate_needed,
  output logic [SEL_W-1:0]     out_selected_count,
  output logic                 out_scan_stopped
);

  item_t   front_item, mid_item;
  result_t back_res, out_res;
  logic    mid_empty, res_full, go;

  hpps_front #(.NUM_VMS(NUM_VMS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .first_of_scan    (in_first_of_scan),
    .now_time         (in_now_time),
    .page_frame       (in_page_frame),
    .page_time        (in_page_time),
    .owner_valid      (in_owner_valid),
    .owner_vm         (in_owner_vm),
    .in_fast_memory   (in_fast_memory),
    .owner_fast_count (in_owner_fast_count),
    .item             (front_item)
  );

  hpps_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (go),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  assign go = !mid_empty && !res_full;

  hpps_back #(
    .NUM_VMS    (NUM_VMS),
    .MAX_SELECT (MAX_SELECT),
    .MAX_PAGES  (MAX_PAGES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .item   (mid_item),
    .result (back_res)
  );

  hpps_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (go),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_selected       = out_res.selected;
  assign out_frame          = out_res.frame;
  assign out_to_fast        = out_res.to_fast;
  assign out_migrate_needed = out_res.migrate_needed;
  assign out_selected_count = out_res.selected_count;
  assign out_scan_stopped   = out_res.scan_stopped;

endmodule

/* sv/hpps_checker.sv */
module hpps_checker import hpps_pkg::*; #(
  parameter int MAX_SELECT = MAX_SELECT_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic               out_selected,
  input logic [FRAME_W-1:0] out_frame,
  input logic               out_to_fast,
  input logic               out_migrate_needed,
  input logic [SEL_W-1:0]   out_selected_count
);

  // nothing to deliver right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_fast_is_sel: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_to_fast |-> out_selected)
    else $error("promotion reported on an unselected page");

  a_promo_migr: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_to_fast |-> out_migrate_needed)
    else $error("promotion without migrate flag");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_selected_count <= SEL_W'(MAX_SELECT))
    else $error("selection count beyond limit");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_frame))
    else $error("stalled result beat changed");

endmodule

bind hot_page_placement_selector_core hpps_checker #(.MAX_SELECT(MAX_SELECT)) u_hpps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_selected       (out_selected),
  .out_frame          (out_frame),
  .out_to_fast        (out_to_fast),
  .out_migrate_needed (out_migrate_needed),
  .out_selected_count (out_selected_count)
);

/* sim/hot_page_placement_selector_core_tb.sv */
`timescale 1ns / 1ps

module hot_page_placement_selector_core_tb;
  import hpps_pkg::*;

  localparam int unsigned RUN_LIMIT = 600000;

  typedef enum logic [1:0] {CAP_OVER, CAP_ROOM, CAP_AT} cap_answer_t;

  typedef struct {
    logic               first;
    logic [TIME_W-1:0]  now;
    logic [FRAME_W-1:0] frame;
    logic [PTIME_W-1:0] ptime;
    logic               owner_ok;
    logic [VM_ID_W-1:0] vm;
    logic               fast;
    logic [COUNT_W-1:0] fcount;
  } page_rec_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WINDOW_W-1:0]  cfg_wdata;
  logic                 in_push;
  logic                 in_full;
  logic                 in_first_of_scan;
  logic [TIME_W-1:0]    in_now_time;
  logic [FRAME_W-1:0]   in_page_frame;
  logic [PTIME_W-1:0]   in_page_time;
  logic                 in_owner_valid;
  logic [VM_ID_W-1:0]   in_owner_vm;
  logic                 in_fast_memory;
  logic [COUNT_W-1:0]   in_owner_fast_count;
  logic                 out_empty;
  logic                 out_pop;
  logic                 out_selected;
  logic [FRAME_W-1:0]   out_frame;
  logic                 out_to_fast;
  logic                 out_migrate_needed;
  logic [SEL_W-1:0]     out_selected_count;
  logic                 out_scan_stopped;

  // placement predictor state, mirrors the block's registers
  logic [WINDOW_W-1:0] cold_window;
  logic [LIMIT_W-1:0]  vm_cap [VM_SLOTS];
  logic [31:0]         fast_track [VM_SLOTS];
  int unsigned         sel_tally;
  int unsigned         page_tally;
  logic                copy_flag;
  logic                halted;

  result_t     pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // traffic shaping
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  logic        pop_steady = 1'b0;
  logic        burst_mode = 1'b0;

  hot_page_placement_selector_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_first_of_scan    (in_first_of_scan),
    .in_now_time         (in_now_time),
    .in_page_frame       (in_page_frame),
    .in_page_time        (in_page_time),
    .in_owner_valid      (in_owner_valid),
    .in_owner_vm         (in_owner_vm),
    .in_fast_memory      (in_fast_memory),
    .in_owner_fast_count (in_owner_fast_count),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_selected        (out_selected),
    .out_frame           (out_frame),
    .out_to_fast         (out_to_fast),
    .out_migrate_needed  (out_migrate_needed),
    .out_selected_count  (out_selected_count),
    .out_scan_stopped    (out_scan_stopped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t judge_page(page_rec_t p);
    result_t             r;
    logic [63:0]         age_limit;
    cap_answer_t         ans;
    logic                pick;
    logic                up;
    logic [VM_IDX_W-1:0] slot;
    pick = 1'b0;
    up = 1'b0;
    slot = p.vm[VM_IDX_W-1:0];
    if (p.first) begin
      foreach (fast_track[i]) fast_track[i] = '0;
      sel_tally = 0;
      page_tally = 0;
      copy_flag = 1'b0;
      halted = 1'b0;
    end
    if (!halted) begin
      page_tally++;
      // fast-page budget is consulted for every scanned page, cold ones too
      if (!p.owner_ok || p.vm >= NUM_VMS_DEF) ans = CAP_OVER;
      else if (vm_cap[slot] == '0) ans = CAP_ROOM;
      else begin
        if (fast_track[slot] == '0) fast_track[slot] = {1'b0, p.fcount};
        if (fast_track[slot] == {1'b0, vm_cap[slot]}) ans = CAP_AT;
        else if (fast_track[slot] < {1'b0, vm_cap[slot]}) begin
          fast_track[slot]++;
          ans = CAP_ROOM;
        end else begin
          fast_track[slot]--;
          ans = CAP_OVER;
        end
      end
      age_limit = {12'd0, p.ptime, 20'd0} + {1'b0, cold_window};
      if (age_limit < {1'b0, p.now}) begin
        pick = 1'b1;
        if (p.fast) copy_flag = 1'b1;
      end else if (!p.fast) begin
        if (ans == CAP_ROOM) begin
          pick = 1'b1;
          up = 1'b1;
          copy_flag = 1'b1;
        end
      end else if (ans == CAP_OVER) begin
        pick = 1'b1;
        copy_flag = 1'b1;
      end
      if (pick) sel_tally++;
      if (sel_tally >= MAX_SELECT_DEF || page_tally >= MAX_PAGES_DEF) halted = 1'b1;
    end
    r.selected = pick;
    r.frame = p.frame;
    r.to_fast = up;
    r.migrate_needed = copy_flag;
    r.selected_count = SEL_W'(sel_tally);
    r.scan_stopped = halted;
    return r;
  endfunction

  function automatic page_rec_t mk_page(logic first, logic [TIME_W-1:0] now,
      logic [FRAME_W-1:0] frame, logic [PTIME_W-1:0] ptime, logic owner_ok,
      logic [VM_ID_W-1:0] vm, logic fast, logic [COUNT_W-1:0] fcount);
    page_rec_t p;
    p.first = first;
    p.now = now;
    p.frame = frame;
    p.ptime = ptime;
    p.owner_ok = owner_ok;
    p.vm = vm;
    p.fast = fast;
    p.fcount = fcount;
    return p;
  endfunction

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_cap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 75) return LIMIT_W'($urandom_range(1, 12));
    if (r < 85) return '1;
    return LIMIT_W'($urandom);
  endfunction

  function automatic logic [TIME_W-1:0] rand_now();
    logic [63:0] t;
    logic [31:0] coarse;
    int unsigned r;
    r = $urandom_range(0, 99);
    coarse = $urandom;
    if (r < 20) return TIME_W'({$urandom, $urandom});
    if (r < 28) return '0;
    if (r < 36) return '1;
    t = {1'b0, cold_window} + {12'd0, coarse, 20'd0} + 64'($urandom_range(0, 1048575));
    return t[63] ? {TIME_W{1'b1}} : t[TIME_W-1:0];
  endfunction

  // cold_pct: share of pages placed safely below the age threshold
  function automatic page_rec_t rand_page(logic first, logic [TIME_W-1:0] now,
      int unsigned cold_pct);
    page_rec_t   p;
    logic [63:0] thr;
    logic [63:0] v;
    p.first = first;
    p.now = now;
    p.frame = $urandom;
    p.owner_ok = ($urandom_range(0, 9) != 0);
    p.vm = ($urandom_range(0, 6) != 0) ? VM_ID_W'($urandom_range(0, 3)) : VM_ID_W'($urandom);
    p.fast = 1'($urandom_range(0, 1));
    thr = (now > cold_window) ? ({1'b0, now} - {1'b0, cold_window}) >> TIME_SHIFT : 64'd0;
    if (thr > 64'hFFFF_FFFF) p.ptime = $urandom;
    else if (thr != 0 && $urandom_range(0, 99) < cold_pct)
      p.ptime = $urandom_range(0, thr[31:0] - 1);
    else if ($urandom_range(0, 3) != 0) begin
      v = thr + 64'($urandom_range(0, 4));
      v = (v >= 2) ? v - 2 : 64'd0;
      p.ptime = (v > 64'hFFFF_FFFF) ? '1 : v[31:0];
    end else p.ptime = $urandom;
    if (p.vm < VM_SLOTS && $urandom_range(0, 4) != 0) begin
      v = {33'd0, vm_cap[p.vm[VM_IDX_W-1:0]]} + 64'($urandom_range(0, 6));
      v = (v >= 3) ? v - 3 : 64'd0;
      p.fcount = (v > 64'h7FFF_FFFF) ? '1 : v[COUNT_W-1:0];
    end else p.fcount = ($urandom_range(0, 3) == 0) ? '0 : COUNT_W'($urandom);
    // occasional junk record
    if ($urandom_range(0, 19) == 0) begin
      p.now = TIME_W'({$urandom, $urandom});
      p.ptime = $urandom;
      p.vm = VM_ID_W'($urandom);
      p.fcount = COUNT_W'($urandom);
    end
    return p;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WINDOW_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_WINDOW) cold_window = val;
    else vm_cap[VM_IDX_W'(idx - CFG_LIMIT_VM0)] = val[LIMIT_W-1:0];
    @(negedge clk) cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // upper write-data bits are junk, only the low 31 land in the limit
  task automatic set_cap(int unsigned vm_i, logic [LIMIT_W-1:0] cap);
    write_reg(CFG_IDX_W'(CFG_LIMIT_VM0 + vm_i), {32'($urandom), cap});
  endtask

  task automatic send_page(page_rec_t p);
    int unsigned idle;
    @(negedge clk);
    in_push <= 1'b1;
    in_first_of_scan <= p.first;
    in_now_time <= p.now;
    in_page_frame <= p.frame;
    in_page_time <= p.ptime;
    in_owner_valid <= p.owner_ok;
    in_owner_vm <= p.vm;
    in_fast_memory <= p.fast;
    in_owner_fast_count <= p.fcount;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_verdicts.push_back(judge_page(p));
    idle = (burst_mode || $urandom_range(0, 99) >= 35) ? 0 : idle_span();
    if (idle != 0) begin
      @(negedge clk) in_push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk) in_push <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_state();
    // no scan start yet: judged against power-on state
    send_page(mk_page(1'b0, '0, 32'h0000_0001, '0, 1'b1, 16'd0, 1'b0, '0));
    send_page(mk_page(1'b0, '1, '1, '1, 1'b1, 16'd1, 1'b1, '1));
    send_page(mk_page(1'b0, '0, 32'h0000_0002, 32'd3, 1'b0, 16'd2, 1'b1, 31'd5));
    send_page(mk_page(1'b0, '0, 32'h0000_0003, 32'd3, 1'b1, 16'd4, 1'b1, 31'd5));
    send_page(mk_page(1'b0, '0, 32'h0000_0004, 32'd3, 1'b1, 16'd2, 1'b1, 31'd5));
  endtask

  task automatic test_cold_edge();
    drain_results();
    write_reg(CFG_WINDOW, '0);
    // age sum equal to now is still hot
    send_page(mk_page(1'b1, 63'h50_0000, 32'h0000_000A, 32'd5, 1'b1, 16'd0, 1'b1, '0));
    send_page(mk_page(1'b0, '1, 32'h0000_0000, '1, 1'b1, 16'd0, 1'b0, '0));
    send_page(mk_page(1'b0, 63'h50_0001, 32'h0000_000B, 32'd5, 1'b1, 16'd0, 1'b1, '0));
    drain_results();
    write_reg(CFG_WINDOW, '1);
    // full window plus latest page time must not wrap
    send_page(mk_page(1'b1, '1, '1, '0, 1'b1, 16'd3, 1'b0, '1));
    send_page(mk_page(1'b0, '1, 32'h5A5A_A5A5, '1, 1'b1, 16'hFFFF, 1'b1, '0));
  endtask

  task automatic test_fast_limits();
    drain_results();
    write_reg(CFG_WINDOW, WINDOW_RESET);
    set_cap(0, 31'd1);
    set_cap(1, 31'd5);
    set_cap(2, '1);
    set_cap(3, 31'd7);
    // now = 0 keeps every page hot; the page with now all ones (frame 132) is cold
    send_page(mk_page(1'b1, '0, 32'h100, 32'd1, 1'b1, 16'd0, 1'b0, '0));
    send_page(mk_page(1'b0, '0, 32'h101, 32'd1, 1'b1, 16'd0, 1'b0, 31'd9));
    send_page(mk_page(1'b0, '0, 32'h102, 32'd1, 1'b1, 16'd0, 1'b1, 31'd9));
    send_page(mk_page(1'b0, '0, 32'h110, 32'd1, 1'b1, 16'd1, 1'b1, 31'd9));
    send_page(mk_page(1'b0, '0, 32'h111, 32'd1, 1'b1, 16'd1, 1'b0, 31'd9));
    send_page(mk_page(1'b0, '0, 32'h112, 32'd1, 1'b1, 16'd1, 1'b1, 31'd9));
    send_page(mk_page(1'b0, '0, 32'h113, 32'd1, 1'b1, 16'd1, 1'b1, 31'd9));
    send_page(mk_page(1'b0, '0, 32'h114, 32'd1, 1'b1, 16'd1, 1'b1, 31'd9));
    send_page(mk_page(1'b0, '0, 32'h120, 32'd1, 1'b1, 16'd2, 1'b0, '1));
    send_page(mk_page(1'b0, '0, 32'h130, 32'd1, 1'b1, 16'd3, 1'b0, 31'd6));
    send_page(mk_page(1'b0, '0, 32'h131, 32'd1, 1'b1, 16'd3, 1'b0, 31'd6));
    send_page(mk_page(1'b0, '1, 32'h132, 32'd1, 1'b1, 16'd3, 1'b0, 31'd6));
    // new scan forgets the tracked counts
    send_page(mk_page(1'b1, '0, 32'h140, 32'd1, 1'b1, 16'd0, 1'b0, 31'd3));
  endtask

  task automatic test_random_scans();
    int unsigned       phase;
    int unsigned       scan_i;
    int unsigned       len;
    int unsigned       k;
    logic [TIME_W-1:0] now;
    for (phase = 0; phase < 6; phase++) begin
      drain_results();
      pop_steady = (phase == 2);
      burst_mode = (phase == 2);
      case (phase)
        0: write_reg(CFG_WINDOW, WINDOW_RESET);
        1: write_reg(CFG_WINDOW, '0);
        2: write_reg(CFG_WINDOW, '1);
        4: write_reg(CFG_WINDOW, WINDOW_W'($urandom) << 12);
        default: write_reg(CFG_WINDOW, WINDOW_W'({$urandom, $urandom}));
      endcase
      if (phase == 1) begin
        set_cap(0, '0);
        set_cap(1, 31'd1);
        set_cap(2, '1);
        set_cap(3, LIMIT_W'($urandom_range(2, 12)));
      end else begin
        for (k = 0; k < VM_SLOTS; k++) set_cap(k, pick_cap());
      end
      for (scan_i = 0; scan_i < 5; scan_i++) begin
        now = rand_now();
        len = $urandom_range(2, 8);
        // now and then a scan just carries on from the last one
        for (k = 0; k < len; k++)
          send_page(rand_page(k == 0 && $urandom_range(0, 9) != 0, now, 20));
      end
    end
    drain_results();
    pop_steady = 1'b0;
    burst_mode = 1'b0;
  endtask

  task automatic test_selection_stop();
    logic [TIME_W-1:0] now;
    int unsigned       n;
    int unsigned       k;
    drain_results();
    write_reg(CFG_WINDOW, WINDOW_RESET);
    for (k = 0; k < VM_SLOTS; k++) set_cap(k, pick_cap());
    // threshold near 2^31 time units, most pages land below it
    now = TIME_W'({1'b0, cold_window} + (64'h8000_0000 << TIME_SHIFT)
                  + 64'($urandom_range(0, 1048575)));
    n = 0;
    do begin
      if (n == 300) begin
        hold_req = 250;
        burst_mode = 1'b1;
      end
      if (n == 360) burst_mode = 1'b0;
      if (n == 600) drain_results();
      send_page(rand_page(n == 0, now, 90));
      n++;
    end while (!halted);
    // past the stop every beat reports stopped and selects nothing until a new scan starts
    repeat (12) send_page(rand_page(1'b0, now, 50));
    send_page(rand_page(1'b1, now, 50));
    repeat (5) send_page(rand_page(1'b0, now, 50));
  endtask

  // result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else if (!pop_steady && $urandom_range(0, 99) < 25) begin
      stall_left = idle_span() - 1;
      out_pop <= 1'b0;
    end else out_pop <= 1'b1;
  end

  always @(posedge clk) begin : check_beat
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_verdicts.size() == 0)
        report_mismatch($sformatf("beat for frame %h with nothing pending", out_frame));
      else begin
        want = pending_verdicts.pop_front();
        if (out_selected !== want.selected)
          report_mismatch($sformatf("frame %h: selected %b, want %b",
                                    want.frame, out_selected, want.selected));
        if (out_frame !== want.frame)
          report_mismatch($sformatf("frame %h, want %h", out_frame, want.frame));
        if (out_to_fast !== want.to_fast)
          report_mismatch($sformatf("frame %h: to_fast %b, want %b",
                                    want.frame, out_to_fast, want.to_fast));
        if (out_migrate_needed !== want.migrate_needed)
          report_mismatch($sformatf("frame %h: migrate_needed %b, want %b",
                                    want.frame, out_migrate_needed, want.migrate_needed));
        if (out_selected_count !== want.selected_count)
          report_mismatch($sformatf("frame %h: selected_count %0d, want %0d",
                                    want.frame, out_selected_count, want.selected_count));
        if (out_scan_stopped !== want.scan_stopped)
          report_mismatch($sformatf("frame %h: scan_stopped %b, want %b",
                                    want.frame, out_scan_stopped, want.scan_stopped));
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog: cycle limit reached with %0d beats outstanding",
             pending_verdicts.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_first_of_scan = 1'b0;
    in_now_time = '0;
    in_page_frame = '0;
    in_page_time = '0;
    in_owner_valid = 1'b0;
    in_owner_vm = '0;
    in_fast_memory = 1'b0;
    in_owner_fast_count = '0;
    out_pop = 1'b0;
    cold_window = WINDOW_RESET;
    foreach (vm_cap[i]) vm_cap[i] = '0;
    foreach (fast_track[i]) fast_track[i] = '0;
    sel_tally = 0;
    page_tally = 0;
    copy_flag = 1'b0;
    halted = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_state();
    test_cold_edge();
    test_fast_limits();
    test_random_scans();
    test_selection_stop();

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* hot_page_placement_selector_core.f */
sv/hpps_pkg.sv
sv/hpps_fifo.sv
sv/hpps_front.sv
sv/hpps_back.sv
sv/hot_page_placement_selector_core.sv
sv/hpps_checker.sv
sim/hot_page_placement_selector_core_tb.sv
